### hdl/soa_pkg.sv
// soa_pkg: shared constants for the slab object allocator
// list codes, register indexes and fixed field widths; no dependencies
`timescale 1ns / 1ps

package soa_pkg;

   localparam int SLAB_W   = 4;
   localparam int OBJ_W    = 8;
   localparam int OFFSET_W = 23;
   localparam int OPS_W    = 9;
   localparam int SIZE_W   = 18;
   localparam int STEP_W   = 13;
   localparam int CCOUNT_W = 8;
   localparam int LIMIT_W  = 5;

   localparam logic [OFFSET_W-1:0] OFFSET_MAX = 23'h7FFFFF;

   typedef logic [1:0] list_type;
   localparam list_type LIST_FREE    = 2'd0;
   localparam list_type LIST_PARTIAL = 2'd1;
   localparam list_type LIST_FULL    = 2'd2;

   typedef logic [2:0] reg_type;
   localparam reg_type REG_OBJECTS  = 3'd0;
   localparam reg_type REG_OBJ_SIZE = 3'd1;
   localparam reg_type REG_COLOR_ST = 3'd2;
   localparam reg_type REG_COLOR_CT = 3'd3;
   localparam reg_type REG_LIMIT    = 3'd4;

endpackage

### hdl/soa_ram.sv
// soa_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module soa_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/slab_object_allocator.sv
// slab_object_allocator: one slab cache with free, partial and full slab lists
// depends on soa_pkg and soa_ram (free-chain store)
`timescale 1ns / 1ps
//
// channel  dir  handshake               payload
// req      in   req_tvalid/req_tready   tuser: operation; tdata: free_slab, free_object
// rsp      out  rsp_tvalid/rsp_tready   tuser: status; tdata: slab_out, object_out, byte_offset
// csr      in   apb psel/penable        five config registers at 4*i
//
// one request at a time, sequenced over a shared multiplier and the chain ram read port;
// alloc and free take the extra unlink and push steps when the slab changes list;
// growing a slab adds a color step and a fill pass, one chain entry written per cycle.
// synchronous reset empties the lists; the chain ram needs no clearing pass.
// req_tready is low from acceptance until the response has been taken.

module slab_object_allocator #(
   parameter int SLABS       = 16,
   parameter int MAX_OBJECTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [3:0] free_slab, [11:4] free_object, rest zero
   input  logic [0:0]  req_tuser,   // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [3:0] slab_out, [11:4] object_out, [34:12] byte_offset
   output logic [0:0]  rsp_tuser,   // [0] status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SW  = $clog2(SLABS + 1);
   localparam int SIW = (SLABS > 1) ? $clog2(SLABS) : 1;
   localparam int IW  = $clog2(MAX_OBJECTS + 1);
   localparam int AW  = $clog2(SLABS * MAX_OBJECTS);
   localparam int MB  = (IW > soa_pkg::CCOUNT_W) ? IW : soa_pkg::CCOUNT_W;
   localparam int PW  = soa_pkg::SIZE_W + MB;

   localparam logic [SW-1:0] NIL       = SW'(SLABS);
   localparam logic [IW-1:0] CHAIN_END = IW'(MAX_OBJECTS);

   typedef struct packed {
      logic [IW-1:0]                head;
      logic [IW-1:0]                in_use;
      logic [soa_pkg::OFFSET_W-1:0] color;
      logic [SW-1:0]                next;
      logic [SW-1:0]                prev;
      soa_pkg::list_type            lst;
   } slab_rec_type;

   typedef enum logic [14:0] {
      ST_IDLE    = 15'b000000000000001,
      ST_A_READ  = 15'b000000000000010,
      ST_A_WAIT  = 15'b000000000000100,
      ST_F_WRITE = 15'b000000000001000,
      ST_PLACE   = 15'b000000000010000,
      ST_UNL_RD  = 15'b000000000100000,
      ST_UNL_P   = 15'b000000001000000,
      ST_UNL_N   = 15'b000000010000000,
      ST_PUSH_S  = 15'b000000100000000,
      ST_PUSH_H  = 15'b000001000000000,
      ST_G_INIT  = 15'b000010000000000,
      ST_G_COLOR = 15'b000100000000000,
      ST_G_FILL  = 15'b001000000000000,
      ST_OFFS    = 15'b010000000000000,
      ST_OUT     = 15'b100000000000000
   } state_type;

   // configuration
   logic [soa_pkg::OPS_W-1:0]    ops_ff;
   logic [soa_pkg::SIZE_W-1:0]   osize_ff;
   logic [soa_pkg::STEP_W-1:0]   cstep_ff;
   logic [soa_pkg::CCOUNT_W-1:0] ccount_ff;
   logic [soa_pkg::LIMIT_W-1:0]  limit_ff;

   // sequencer state
   state_type             state_ff, state_in, ret_ff, ret_in;
   logic [SW-1:0]         s_ff, s_in, p_ff, p_in, n_ff, n_in, h_ff, h_in;
   logic [IW-1:0]         idx_ff, idx_in, cnt_ff, cnt_in;
   soa_pkg::list_type     tgt_ff, tgt_in, lst_ff, lst_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic [SW-1:0]         heads_ff [3];
   logic [SW-1:0]         heads_in [3];
   logic [SW-1:0]         grown_ff, grown_in;
   logic [soa_pkg::CCOUNT_W-1:0] color_ff, color_in;

   // result
   logic                         status_ff, status_in;
   logic [soa_pkg::SLAB_W-1:0]   oslab_ff, oslab_in;
   logic [soa_pkg::OBJ_W-1:0]    oobj_ff, oobj_in;
   logic [soa_pkg::OFFSET_W-1:0] off_ff, off_in;

   // per-slab records
   slab_rec_type slab_ff [SLABS];
   slab_rec_type rec_rd, rec_wr;
   logic [SIW-1:0] sa;
   logic           rec_we;

   // chain ram
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_addr;
   logic [IW-1:0] ram_wdata, ram_rdata;

   logic [IW-1:0] eff_num;

   function automatic logic [AW-1:0] chain_addr(input logic [SW-1:0] s,
                                                input logic [IW-1:0] i);
      chain_addr = AW'(s) * AW'(MAX_OBJECTS) + AW'(i);
   endfunction

   function automatic soa_pkg::reg_type reg_type_of(input logic [4:0] addr);
      reg_type_of = addr[4:2];
   endfunction

   soa_ram #(
      .WIDTH (IW),
      .DEPTH (SLABS * MAX_OBJECTS)
   ) u_chain (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_addr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_addr),
      .rd_data (ram_rdata)
   );

   // objects per slab clamped to 1..MAX_OBJECTS
   always_comb begin
      if (ops_ff == '0) begin
         eff_num = IW'(1);
      end else if (32'(ops_ff) > MAX_OBJECTS) begin
         eff_num = CHAIN_END;
      end else begin
         eff_num = IW'(ops_ff);
      end
   end

   assign rec_rd = slab_ff[sa];

   // configuration port
   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      case (reg_type_of(csr_paddr))
         soa_pkg::REG_OBJECTS:  csr_prdata = 32'(ops_ff);
         soa_pkg::REG_OBJ_SIZE: csr_prdata = 32'(osize_ff);
         soa_pkg::REG_COLOR_ST: csr_prdata = 32'(cstep_ff);
         soa_pkg::REG_COLOR_CT: csr_prdata = 32'(ccount_ff);
         soa_pkg::REG_LIMIT:    csr_prdata = 32'(limit_ff);
         default:               csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ops_ff    <= soa_pkg::OPS_W'(256);
         osize_ff  <= soa_pkg::SIZE_W'(32);
         cstep_ff  <= soa_pkg::STEP_W'(64);
         ccount_ff <= '0;
         limit_ff  <= soa_pkg::LIMIT_W'(16);
      end else if (csr_wr) begin
         case (reg_type_of(csr_paddr))
            soa_pkg::REG_OBJECTS:  ops_ff    <= csr_pwdata[soa_pkg::OPS_W-1:0];
            soa_pkg::REG_OBJ_SIZE: osize_ff  <= csr_pwdata[soa_pkg::SIZE_W-1:0];
            soa_pkg::REG_COLOR_ST: cstep_ff  <= csr_pwdata[soa_pkg::STEP_W-1:0];
            soa_pkg::REG_COLOR_CT: ccount_ff <= csr_pwdata[soa_pkg::CCOUNT_W-1:0];
            soa_pkg::REG_LIMIT:    limit_ff  <= csr_pwdata[soa_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {5'd0, off_ff, oobj_ff, oslab_ff};
   assign rsp_tuser  = status_ff;

   always_comb begin
      logic [soa_pkg::SLAB_W-1:0] fs;
      logic [soa_pkg::OBJ_W-1:0]  fo;
      logic                       free_ok;
      logic                       can_grow;
      logic [IW-1:0]              head_idx;
      logic [SW-1:0]              h;
      logic [soa_pkg::SIZE_W-1:0] mul_a;
      logic [MB-1:0]              mul_b;
      logic                       mul_go;
      logic [PW:0]                sum;
      logic [IW-1:0]              cnt_next;
      logic [soa_pkg::CCOUNT_W-1:0] col_next;
      soa_pkg::list_type          place_tgt;

      fs       = req_tdata[3:0];
      fo       = req_tdata[11:4];
      free_ok  = (32'(fs) < 32'(grown_ff)) && (32'(fs) < SLABS) && (32'(fo) < MAX_OBJECTS);
      can_grow = (32'(grown_ff) < 32'(limit_ff)) && (32'(grown_ff) < SLABS);
      head_idx = (32'(rec_rd.head) >= MAX_OBJECTS) ? '0 : rec_rd.head;
      h        = heads_ff[tgt_ff];
      sum      = (PW + 1)'(rec_rd.color) + (PW + 1)'(prod_ff);
      cnt_next = cnt_ff + IW'(1);
      col_next = color_ff + soa_pkg::CCOUNT_W'(1);
      place_tgt = soa_pkg::LIST_PARTIAL;
      mul_a    = osize_ff;
      mul_b    = MB'(idx_ff);
      mul_go   = 1'b0;

      state_in  = state_ff;
      ret_in    = ret_ff;
      s_in      = s_ff;
      p_in      = p_ff;
      n_in      = n_ff;
      h_in      = h_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      tgt_in    = tgt_ff;
      lst_in    = lst_ff;
      heads_in  = heads_ff;
      grown_in  = grown_ff;
      color_in  = color_ff;
      status_in = status_ff;
      oslab_in  = oslab_ff;
      oobj_in   = oobj_ff;
      off_in    = off_ff;
      sa        = s_ff[SIW-1:0];
      rec_we    = 1'b0;
      rec_wr    = rec_rd;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_addr  = chain_addr(s_ff, idx_ff);
      ram_wdata = rec_rd.head;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               status_in = 1'b0;
               off_in    = '0;
               if (req_tuser[0]) begin
                  oslab_in = fs;
                  oobj_in  = fo;
                  s_in     = SW'(fs);
                  idx_in   = IW'(fo);
                  state_in = free_ok ? ST_F_WRITE : ST_OUT;
               end else if (heads_ff[soa_pkg::LIST_PARTIAL] != NIL) begin
                  s_in     = heads_ff[soa_pkg::LIST_PARTIAL];
                  state_in = ST_A_READ;
               end else if (heads_ff[soa_pkg::LIST_FREE] != NIL) begin
                  s_in     = heads_ff[soa_pkg::LIST_FREE];
                  tgt_in   = soa_pkg::LIST_PARTIAL;
                  ret_in   = ST_A_READ;
                  state_in = ST_UNL_RD;
               end else if (can_grow) begin
                  s_in     = grown_ff;
                  state_in = ST_G_INIT;
               end else begin
                  status_in = 1'b1;
                  oslab_in  = '0;
                  oobj_in   = '0;
                  state_in  = ST_OUT;
               end
            end
         end
         ST_A_READ: begin
            idx_in   = head_idx;
            ram_addr = chain_addr(s_ff, head_idx);
            ram_re   = 1'b1;
            mul_b    = MB'(head_idx);
            mul_go   = 1'b1;
            state_in = ST_A_WAIT;
         end
         ST_A_WAIT: begin
            rec_wr.head = ram_rdata;
            if (rec_rd.in_use != '1) begin
               rec_wr.in_use = rec_rd.in_use + IW'(1);
            end
            rec_we   = 1'b1;
            oslab_in = soa_pkg::SLAB_W'(s_ff);
            oobj_in  = soa_pkg::OBJ_W'(idx_ff);
            state_in = ST_PLACE;
         end
         ST_F_WRITE: begin
            ram_we      = 1'b1;
            rec_wr.head = idx_ff;
            if (rec_rd.in_use != '0) begin
               rec_wr.in_use = rec_rd.in_use - IW'(1);
            end
            rec_we   = 1'b1;
            mul_go   = 1'b1;
            state_in = ST_PLACE;
         end
         ST_PLACE: begin
            if (rec_rd.in_use == '0) begin
               place_tgt = soa_pkg::LIST_FREE;
            end else if (rec_rd.in_use >= eff_num) begin
               place_tgt = soa_pkg::LIST_FULL;
            end
            if (place_tgt != rec_rd.lst) begin
               tgt_in   = place_tgt;
               ret_in   = ST_OFFS;
               state_in = ST_UNL_RD;
            end else begin
               state_in = ST_OFFS;
            end
         end
         ST_UNL_RD: begin
            p_in     = rec_rd.prev;
            n_in     = rec_rd.next;
            lst_in   = rec_rd.lst;
            state_in = ST_UNL_P;
         end
         ST_UNL_P: begin
            if (p_ff != NIL) begin
               sa          = p_ff[SIW-1:0];
               rec_wr.next = n_ff;
               rec_we      = 1'b1;
            end else begin
               heads_in[lst_ff] = n_ff;
            end
            state_in = ST_UNL_N;
         end
         ST_UNL_N: begin
            if (n_ff != NIL) begin
               sa          = n_ff[SIW-1:0];
               rec_wr.prev = p_ff;
               rec_we      = 1'b1;
            end
            state_in = ST_PUSH_S;
         end
         ST_PUSH_S: begin
            rec_wr.next      = h;
            rec_wr.prev      = NIL;
            rec_wr.lst       = tgt_ff;
            rec_we           = 1'b1;
            heads_in[tgt_ff] = s_ff;
            h_in             = h;
            state_in         = ST_PUSH_H;
         end
         ST_PUSH_H: begin
            if (h_ff != NIL) begin
               sa          = h_ff[SIW-1:0];
               rec_wr.prev = s_ff;
               rec_we      = 1'b1;
            end
            state_in = ret_ff;
         end
         ST_G_INIT: begin
            mul_a    = soa_pkg::SIZE_W'(cstep_ff);
            mul_b    = MB'(color_ff);
            mul_go   = 1'b1;
            grown_in = grown_ff + SW'(1);
            color_in = (col_next >= ccount_ff) ? '0 : col_next;
            cnt_in   = '0;
            state_in = ST_G_COLOR;
         end
         ST_G_COLOR: begin
            rec_wr.color  = (prod_ff > PW'(soa_pkg::OFFSET_MAX)) ? soa_pkg::OFFSET_MAX
                                                                : prod_ff[soa_pkg::OFFSET_W-1:0];
            rec_wr.head   = '0;
            rec_wr.in_use = '0;
            rec_we        = 1'b1;
            state_in      = ST_G_FILL;
         end
         ST_G_FILL: begin
            // link object i to i+1, last one ends the chain
            ram_we    = 1'b1;
            ram_addr  = chain_addr(s_ff, cnt_ff);
            ram_wdata = (cnt_next < eff_num) ? cnt_next : CHAIN_END;
            cnt_in    = cnt_next;
            if (cnt_next >= eff_num) begin
               tgt_in   = soa_pkg::LIST_PARTIAL;
               ret_in   = ST_A_READ;
               state_in = ST_PUSH_S;
            end
         end
         ST_OFFS: begin
            off_in   = (sum > (PW + 1)'(soa_pkg::OFFSET_MAX)) ? soa_pkg::OFFSET_MAX
                                                             : sum[soa_pkg::OFFSET_W-1:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      prod_in = mul_go ? PW'(mul_a) * PW'(mul_b) : prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         heads_ff <= '{NIL, NIL, NIL};
         grown_ff <= '0;
         color_ff <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         heads_ff <= heads_in;
         grown_ff <= grown_in;
         color_ff <= color_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff      <= s_in;
      p_ff      <= p_in;
      n_ff      <= n_in;
      h_ff      <= h_in;
      idx_ff    <= idx_in;
      cnt_ff    <= cnt_in;
      tgt_ff    <= tgt_in;
      lst_ff    <= lst_in;
      prod_ff   <= prod_in;
      status_ff <= status_in;
      oslab_ff  <= oslab_in;
      oobj_ff   <= oobj_in;
      off_ff    <= off_in;
      if (rec_we) begin
         slab_ff[sa] <= rec_wr;
      end
   end

endmodule
